FILE: hdl/stb_pkg.sv
// stb_pkg: shared types, constants and command codes for the software timer bank
// used by stb_cell and software_timer_bank_top; no dependencies
`default_nettype none

package stb_pkg;

  // bank geometry
  localparam int SLOTS      = 16;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W      = 8;
  localparam int PERIOD_W   = 16;
  localparam int STEP_W     = 16;
  localparam int OUT_W      = 16;
  localparam int OUT_SLOT_W = 4;
  localparam int CMP_W      = (COUNT_BITS > STEP_W) ? COUNT_BITS : STEP_W;

  // item kinds
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_TICK  = 3'd2;
  localparam logic [2:0] KIND_BULK  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // slot modes
  localparam logic [1:0] MODE_CSET   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_CTOG   = 2'd2;
  localparam logic [1:0] MODE_IDLE   = 2'd3;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [STEP_W-1:0] BULK_STEP_RESET = 16'd40;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [SLOT_BITS-1:0]  idx_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [OUT_SLOT_W-1:0] out_slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   is_start;
    logic   is_stop;
    logic   is_clear;
    logic   is_tick;
    logic   glob_hit;
    key_t   key;
    count_t period;
    logic [1:0] mode;
    cmp_t   step;
  } cmd_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic all_used;
    idx_t free_idx;
  } link_t;

endpackage

`default_nettype wire

FILE: hdl/stb_cell.sv
// stb_cell: one timer slot with its key, count, period, mode and flag
// depends on stb_pkg; chained by software_timer_bank_top
`default_nettype none

module stb_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire stb_pkg::idx_t  my_idx,
  input  wire stb_pkg::cmd_t  cmd,
  input  wire stb_pkg::link_t link_in,
  output stb_pkg::link_t      link_out,
  output logic                flag_nxt,
  output logic                expired
);

  stb_pkg::count_t count_r, count_nxt;
  stb_pkg::count_t period_r, period_nxt;
  logic [1:0]      mode_r, mode_nxt;
  stb_pkg::key_t   key_r, key_nxt;
  logic            valid_r, valid_nxt;
  logic            used_r, used_nxt;
  logic            flag_r;

  logic            match;
  logic            alloc;
  logic            take_start;
  stb_pkg::cmp_t   count_ext;

  // lookup and allocation
  assign match      = valid_r && (key_r == cmd.key);
  assign alloc      = cmd.is_start && !cmd.glob_hit && !used_r && link_in.all_used;
  assign take_start = (cmd.is_start && match) || alloc;
  assign count_ext  = stb_pkg::cmp_t'(count_r);

  // chain toward the next cell
  always_comb begin
    link_out.hit      = link_in.hit | match;
    link_out.hit_idx  = link_in.hit ? link_in.hit_idx : my_idx;
    link_out.all_used = link_in.all_used & used_r;
    link_out.free_idx = (link_in.all_used && !used_r) ? my_idx : link_in.free_idx;
  end

  // slot update
  always_comb begin
    count_nxt  = count_r;
    period_nxt = period_r;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    valid_nxt  = valid_r;
    used_nxt   = used_r;
    flag_nxt   = flag_r;
    expired    = 1'b0;
    if (alloc) begin
      key_nxt   = cmd.key;
      valid_nxt = 1'b1;
      used_nxt  = 1'b1;
    end
    if (take_start) begin
      period_nxt = cmd.period;
      if (cmd.mode == stb_pkg::MODE_SINGLE) begin
        count_nxt = cmd.period;
      end
      mode_nxt = cmd.mode;
    end
    if (cmd.is_stop && match) begin
      valid_nxt = 1'b0;
      mode_nxt  = stb_pkg::MODE_IDLE;
    end
    if (cmd.is_clear && match) begin
      flag_nxt = 1'b0;
    end
    if (cmd.is_tick && (mode_r != stb_pkg::MODE_IDLE)) begin
      if ((count_ext >= cmd.step) && (count_r != '0)) begin
        count_nxt = stb_pkg::count_t'(count_ext - cmd.step);
      end else if (cmd.step != '0) begin
        // expiry
        count_nxt = '0;
        expired   = 1'b1;
        case (mode_r)
          stb_pkg::MODE_CSET: begin
            count_nxt = period_r;
            flag_nxt  = 1'b1;
          end
          stb_pkg::MODE_SINGLE: begin
            flag_nxt = 1'b1;
            mode_nxt = stb_pkg::MODE_IDLE;
          end
          stb_pkg::MODE_CTOG: begin
            count_nxt = period_r;
            flag_nxt  = !flag_r;
          end
          default: begin
            count_nxt = '0;
          end
        endcase
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      period_r <= '0;
      mode_r   <= stb_pkg::MODE_IDLE;
      valid_r  <= 1'b0;
      used_r   <= 1'b0;
      flag_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      period_r <= period_nxt;
      mode_r   <= mode_nxt;
      valid_r  <= valid_nxt;
      used_r   <= used_nxt;
      flag_r   <= flag_nxt;
    end
  end

  // key storage, only read while valid
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/software_timer_bank_top.sv
// software_timer_bank_top: keyed bank of timer slots built as a row of stb_cell
// depends on stb_pkg and stb_cell
//
// Usage:
//   Input channel (in_valid / in_stall): one word per item with kind, key,
//   period and mode. Kinds are start, stop, tick, bulk tick and clear flag.
//   Result channel (out_valid / out_stall): one word per item with status,
//   slot, the flag of every slot and the slots that expired on a tick.
//   Config channel (cfg_valid / cfg_ready): writes bulk_step; cfg_ready is always
//   high. The user makes writes only while the bank is idle; the block does not enforce it.
//   The result of an item is registered and appears in the cycle after it is accepted.
//   Throughput: one item per cycle while no stalled result holds the input;
//   every cell looks up, allocates and counts in the cycle of acceptance,
//   with the lookup and free-slot search rippling once along the row of cells.
//   A stalled result holds the output register and the input stalls in
//   that cycle, so no item is taken until the result is gone.
//   Reset (rst_n low, synchronous): all slots idle with zero count, no keys,
//   flags clear, bulk_step back to 40, no result pending.
`default_nettype none

module software_timer_bank_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [7:0]  in_key,
  input  wire logic [15:0] in_period,
  input  wire logic [1:0]  in_mode,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [3:0]       out_slot,
  output logic [15:0]      out_flag_bits,
  output logic [15:0]      out_expired_bits,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_bulk_step
);

  logic [stb_pkg::STEP_W-1:0] bulk_step_r;
  logic                       out_valid_r;
  logic                       status_r, status_nxt;
  stb_pkg::out_slot_t         slot_r, slot_nxt;
  logic [stb_pkg::OUT_W-1:0]  flags_r, flags_nxt;
  logic [stb_pkg::OUT_W-1:0]  expired_r, expired_nxt;

  logic                       fire;
  stb_pkg::cmd_t              cmd;
  stb_pkg::link_t             link [stb_pkg::SLOTS+1];
  logic [stb_pkg::SLOTS-1:0]  cell_flag;
  logic [stb_pkg::SLOTS-1:0]  cell_expired;
  logic                       hit;
  logic                       full;

  assign fire      = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  assign hit  = link[stb_pkg::SLOTS].hit;
  assign full = link[stb_pkg::SLOTS].all_used;

  // command decode
  always_comb begin
    cmd.is_start = fire && (in_kind == stb_pkg::KIND_START);
    cmd.is_stop  = fire && (in_kind == stb_pkg::KIND_STOP);
    cmd.is_clear = fire && (in_kind == stb_pkg::KIND_CLEAR);
    cmd.is_tick  = fire && ((in_kind == stb_pkg::KIND_TICK) ||
                            (in_kind == stb_pkg::KIND_BULK));
    cmd.glob_hit = hit;
    cmd.key      = in_key;
    cmd.period   = stb_pkg::count_t'(in_period);
    cmd.mode     = in_mode;
    cmd.step     = (in_kind == stb_pkg::KIND_BULK) ? stb_pkg::cmp_t'(bulk_step_r)
                                                   : stb_pkg::cmp_t'(1);
  end

  // chain head
  always_comb begin
    link[0].hit      = 1'b0;
    link[0].hit_idx  = '0;
    link[0].all_used = 1'b1;
    link[0].free_idx = '0;
  end

  // row of slot cells
  for (genvar i = 0; i < stb_pkg::SLOTS; i++) begin : g_cell
    stb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (stb_pkg::idx_t'(i)),
      .cmd      (cmd),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .flag_nxt (cell_flag[i]),
      .expired  (cell_expired[i])
    );
  end

  // visible flag and expiry bits
  for (genvar j = 0; j < stb_pkg::OUT_W; j++) begin : g_bits
    if (j < stb_pkg::SLOTS) begin : g_on
      assign flags_nxt[j]   = cell_flag[j];
      assign expired_nxt[j] = cell_expired[j];
    end else begin : g_off
      assign flags_nxt[j]   = 1'b0;
      assign expired_nxt[j] = 1'b0;
    end
  end

  // status and slot of the result word
  always_comb begin
    status_nxt = stb_pkg::STATUS_OK;
    slot_nxt   = '0;
    case (in_kind)
      stb_pkg::KIND_START: begin
        if (hit) begin
          slot_nxt = stb_pkg::out_slot_t'(link[stb_pkg::SLOTS].hit_idx);
        end else if (full) begin
          status_nxt = stb_pkg::STATUS_FAIL;
        end else begin
          slot_nxt = stb_pkg::out_slot_t'(link[stb_pkg::SLOTS].free_idx);
        end
      end
      stb_pkg::KIND_STOP, stb_pkg::KIND_CLEAR: begin
        if (hit) begin
          slot_nxt = stb_pkg::out_slot_t'(link[stb_pkg::SLOTS].hit_idx);
        end else begin
          status_nxt = stb_pkg::STATUS_FAIL;
        end
      end
      default: begin
        status_nxt = stb_pkg::STATUS_OK;
      end
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bulk_step_r <= stb_pkg::BULK_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bulk_step_r <= cfg_bulk_step;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status_nxt;
      slot_r    <= slot_nxt;
      flags_r   <= flags_nxt;
      expired_r <= expired_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_slot         = slot_r;
  assign out_flag_bits    = flags_r;
  assign out_expired_bits = expired_r;

endmodule

`default_nettype wire

FILE: hdl/stb_checker.sv
// stb_checker: port-level checks on software_timer_bank_top, attached by bind
// depends on software_timer_bank_top ports only
`default_nettype none

module stb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_status,
  input wire logic [3:0]  out_slot,
  input wire logic [15:0] out_flag_bits,
  input wire logic [15:0] out_expired_bits
);

  // no result word right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word pending after reset");

  // every accepted item gives a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item gave no result");

  // no result word appears without an accepted item
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && !in_stall) && !(out_valid && out_stall)) |=> !out_valid)
    else $error("result word without an item");

  // a failed lookup reports slot zero and no expiry
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> ((out_slot == 4'd0) && (out_expired_bits == 16'd0)))
    else $error("failed item reports a slot or expiry");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
      $stable(out_slot) && $stable(out_flag_bits) && $stable(out_expired_bits)))
    else $error("stalled result word changed");

endmodule

bind software_timer_bank_top stb_checker u_stb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_slot         (out_slot),
  .out_flag_bits    (out_flag_bits),
  .out_expired_bits (out_expired_bits)
);

`default_nettype wire

FILE: tb/software_timer_bank_top_tb.sv
// software_timer_bank_top_tb: self-checking bench for the keyed timer slot bank
// mirrors the slot table in a scoreboard class and checks every result word
// depends on stb_pkg and software_timer_bank_top
`default_nettype none

module software_timer_bank_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_WORDS = 300;
  localparam stb_pkg::key_t KEY_POOL [6] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'hC3};

  // one result word as the block returns it
  typedef struct packed {
    logic                      status;
    logic [3:0]                slot;
    logic [stb_pkg::OUT_W-1:0] flags;
    logic [stb_pkg::OUT_W-1:0] expired;
  } reply_t;

  // mirror of the slot table and the queue of replies it owes
  class timer_table_mirror;
    logic [stb_pkg::STEP_W-1:0] step;
    stb_pkg::count_t cnt   [stb_pkg::SLOTS];
    stb_pkg::count_t per   [stb_pkg::SLOTS];
    logic [1:0]      md    [stb_pkg::SLOTS];
    stb_pkg::key_t   keyv  [stb_pkg::SLOTS];
    bit              live  [stb_pkg::SLOTS];
    bit              flg   [stb_pkg::SLOTS];
    int              used;
    int              errors;
    reply_t          due_replies [$];

    function new();
      step = stb_pkg::BULK_STEP_RESET;
      for (int i = 0; i < stb_pkg::SLOTS; i++) begin
        cnt[i]  = '0;
        per[i]  = '0;
        md[i]   = stb_pkg::MODE_IDLE;
        keyv[i] = '0;
        live[i] = 1'b0;
        flg[i]  = 1'b0;
      end
      used   = 0;
      errors = 0;
    endfunction

    // only slots already handed out with a live key can match
    function int find_slot(stb_pkg::key_t k);
      for (int i = 0; i < used; i++)
        if (live[i] && keyv[i] == k) return i;
      return -1;
    endfunction

    // count down every running slot, return the slots that expired
    function logic [stb_pkg::OUT_W-1:0] advance(logic [stb_pkg::STEP_W-1:0] amt);
      logic [stb_pkg::OUT_W-1:0] hit;
      hit = '0;
      for (int i = 0; i < used; i++) begin
        if (md[i] == stb_pkg::MODE_IDLE) continue;
        if (cnt[i] >= amt && cnt[i] != 0) begin
          cnt[i] = cnt[i] - amt;
        end else if (amt == 0) begin
          continue;
        end else begin
          cnt[i] = '0;
          case (md[i])
            stb_pkg::MODE_CSET: begin
              cnt[i] = per[i];
              flg[i] = 1'b1;
            end
            stb_pkg::MODE_SINGLE: begin
              flg[i] = 1'b1;
              md[i]  = stb_pkg::MODE_IDLE;
            end
            stb_pkg::MODE_CTOG: begin
              cnt[i] = per[i];
              flg[i] = !flg[i];
            end
            default: ;
          endcase
          if (i < stb_pkg::OUT_W) hit[i] = 1'b1;
        end
      end
      return hit;
    endfunction

    // apply one accepted input word and queue the reply it causes
    function void take_item(logic [2:0] kind, stb_pkg::key_t key, logic [15:0] period,
                            logic [1:0] mode);
      reply_t r;
      int     s;
      r = '0;
      s = find_slot(key);
      case (kind)
        stb_pkg::KIND_START: begin
          if (s < 0 && used >= stb_pkg::SLOTS) begin
            r.status = stb_pkg::STATUS_FAIL;
          end else begin
            if (s < 0) begin
              s       = used;
              keyv[s] = key;
              live[s] = 1'b1;
              used++;
            end
            per[s] = period;
            if (mode == stb_pkg::MODE_SINGLE) cnt[s] = period;
            md[s]  = mode;
            r.slot = 4'(s);
          end
        end
        stb_pkg::KIND_STOP: begin
          if (s < 0) begin
            r.status = stb_pkg::STATUS_FAIL;
          end else begin
            live[s] = 1'b0;
            md[s]   = stb_pkg::MODE_IDLE;
            r.slot  = 4'(s);
          end
        end
        stb_pkg::KIND_TICK: r.expired = advance(1);
        stb_pkg::KIND_BULK: r.expired = advance(step);
        stb_pkg::KIND_CLEAR: begin
          if (s < 0) begin
            r.status = stb_pkg::STATUS_FAIL;
          end else begin
            flg[s] = 1'b0;
            r.slot = 4'(s);
          end
        end
        default: ;
      endcase
      for (int i = 0; i < stb_pkg::SLOTS && i < stb_pkg::OUT_W; i++) r.flags[i] = flg[i];
      due_replies.push_back(r);
    endfunction

    function void compare(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      end
    endfunction

    // check one result word against the oldest owed reply
    function void check_reply(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual %h", $time, got);
        return;
      end
      want = due_replies.pop_front();
      compare("status", 16'(want.status), 16'(got.status));
      compare("slot", 16'(want.slot), 16'(got.slot));
      compare("flag_bits", want.flags, got.flags);
      compare("expired_bits", want.expired, got.expired);
    endfunction
  endclass

  // clock, reset and block inputs
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [2:0]  in_kind = stb_pkg::KIND_TICK;
  logic [7:0]  in_key = '0;
  logic [15:0] in_period = '0;
  logic [1:0]  in_mode = stb_pkg::MODE_CSET;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_bulk_step = stb_pkg::BULK_STEP_RESET;

  logic        in_stall;
  logic        out_valid;
  logic        out_status;
  logic [3:0]  out_slot;
  logic [15:0] out_flag_bits;
  logic [15:0] out_expired_bits;
  logic        cfg_ready;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;

  timer_table_mirror book = new();

  software_timer_bank_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .in_period        (in_period),
    .in_mode          (in_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_flag_bits    (out_flag_bits),
    .out_expired_bits (out_expired_bits),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bulk_step    (cfg_bulk_step)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.check_reply('{out_status, out_slot, out_flag_bits, out_expired_bits});
  end

  // result side pacing: random stall bursts, plus one long hold on request
  initial begin : sink_pacing
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one input word, with an optional gap first, and note it once taken
  task automatic send_word(logic [2:0] kind, stb_pkg::key_t key, logic [15:0] period,
                           logic [1:0] mode);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_key    <= key;
    in_period <= period;
    in_mode   <= mode;
    do @(posedge clk); while (in_stall);
    book.take_item(kind, key, period, mode);
  endtask

  // stop offering and wait until every owed reply has arrived
  task automatic settle();
    in_valid <= 1'b0;
    while (book.due_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_step(logic [15:0] v);
    cfg_valid     <= 1'b1;
    cfg_bulk_step <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.step = v;
  endtask

  function automatic stb_pkg::key_t pick_key();
    if ($urandom_range(0, 49) == 0) return stb_pkg::key_t'($urandom_range(0, 255));
    return KEY_POOL[$urandom_range(0, 5)];
  endfunction

  // mostly short periods so slots expire often
  function automatic logic [15:0] pick_period();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return 16'($urandom_range(0, 12));
    if (p < 9) return 16'($urandom_range(0, 200));
    return 16'($urandom_range(0, 65535));
  endfunction

  // random word, weighted toward starts and ticks
  task automatic rand_word();
    int            pick;
    logic [2:0]    kind;
    stb_pkg::key_t key;
    logic [15:0]   period;
    logic [1:0]    mode;
    pick   = $urandom_range(0, 99);
    key    = pick_key();
    period = pick_period();
    mode   = 2'($urandom_range(0, 2));
    if (pick < 25) begin
      kind = stb_pkg::KIND_START;
      if ($urandom_range(0, 49) == 0) mode = stb_pkg::MODE_IDLE;
    end else if (pick < 27) begin
      kind = stb_pkg::KIND_STOP;
      if ($urandom_range(0, 1) == 1) key = stb_pkg::key_t'($urandom_range(0, 255));
    end else if (pick < 62) begin
      kind = stb_pkg::KIND_TICK;
    end else if (pick < 80) begin
      kind = stb_pkg::KIND_BULK;
    end else if (pick < 97) begin
      kind = stb_pkg::KIND_CLEAR;
    end else begin
      kind = 3'(stb_pkg::KIND_CLEAR + $urandom_range(1, 3));
    end
    send_word(kind, key, period, mode);
  endtask

  initial begin : stimulus
    logic [15:0] phase_steps [5];
    phase_steps = '{16'd3, 16'hFFFF, 16'd1, 16'($urandom_range(1, 65535)), 16'd40};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: tick does nothing, lookups miss
    send_word(stb_pkg::KIND_TICK, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_STOP, 8'h11, 16'h0000, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_CLEAR, 8'h11, 16'h0000, stb_pkg::MODE_CSET);
    // one slot per mode, continuous slots start with zero count
    send_word(stb_pkg::KIND_START, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_START, 8'hFF, 16'hFFFF, stb_pkg::MODE_SINGLE);
    send_word(stb_pkg::KIND_START, 8'h5A, 16'h0003, stb_pkg::MODE_CTOG);
    send_word(stb_pkg::KIND_START, 8'hA5, 16'h0007, stb_pkg::MODE_IDLE);
    send_word(stb_pkg::KIND_TICK, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_TICK, 8'hFF, 16'hFFFF, stb_pkg::MODE_IDLE);
    send_word(stb_pkg::KIND_BULK, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    // update an existing key, clear, stop keeps the flag
    send_word(stb_pkg::KIND_START, 8'h5A, 16'h0001, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_CLEAR, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_STOP, 8'h5A, 16'h0000, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_TICK, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_CLEAR, 8'h5A, 16'h0000, stb_pkg::MODE_CSET);
    // unused kinds change nothing
    send_word(3'(stb_pkg::KIND_CLEAR + 1), 8'hFF, 16'hFFFF, stb_pkg::MODE_IDLE);
    send_word(3'(stb_pkg::KIND_CLEAR + 3), 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    // stopped key comes back in a fresh slot, single with zero period
    send_word(stb_pkg::KIND_START, 8'h5A, 16'h0002, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_START, 8'h3C, 16'h0000, stb_pkg::MODE_SINGLE);
    send_word(stb_pkg::KIND_TICK, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    settle();

    // widest bulk step: every running slot whose count is below it expires
    write_step(16'hFFFF);
    send_word(stb_pkg::KIND_BULK, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_BULK, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    settle();
    write_step(16'd1);
    send_word(stb_pkg::KIND_BULK, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    send_word(stb_pkg::KIND_TICK, 8'h00, 16'h0000, stb_pkg::MODE_CSET);
    settle();

    // random phases, one bulk step each
    for (int ph = 0; ph < 5; ph++) begin
      write_step(phase_steps[ph]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 1 && n == 40) hold_req = 1'b1;
        rand_word();
      end
      settle();
    end

    // last part: no idling, fill the table so starts on new keys fail
    calm = 1'b1;
    write_step(16'($urandom_range(1, 8)));
    for (int n = 0; n < 18; n++)
      send_word(stb_pkg::KIND_START, stb_pkg::key_t'($urandom_range(0, 255)),
                pick_period(), 2'($urandom_range(0, 2)));
    for (int n = 0; n < 150; n++) rand_word();
    settle();

    if (book.errors == 0 && book.due_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
